// ----- hdl/oust_pkg.sv -----
// Shared constants, codes and types of the ordered unique set table.
`default_nettype none
package oust_pkg;

	// Table size and key width
	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;

	// Port field widths
	localparam int ACTION_W = 2;
	localparam int KEY_PORT_W = 32;
	localparam int POS_W = 4;
	localparam int COUNT_W = 5;
	localparam int STATUS_W = 2;

	// Derived storage widths
	localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
	localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Request codes
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	// One finished result
	typedef struct packed {
		logic found;
		logic [POS_W-1:0] position;
		logic [COUNT_W-1:0] entry_count;
		logic [STATUS_W-1:0] status;
	} res_t;

	// Access of the sequencer to the entry memory
	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		logic [KEY_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage
`default_nettype wire

// ----- hdl/oust_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module oust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word and read one word; the read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/oust_ctrl.sv -----
// Sequencer: scans the entries with one comparator, appends, and compacts on remove.
`default_nettype none
module oust_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [oust_pkg::ACTION_W-1:0] action,
	input wire logic [oust_pkg::KEY_PORT_W-1:0] key,
	output logic idle,
	output oust_pkg::ram_req_t ram_req,
	input wire logic [oust_pkg::KEY_W-1:0] rd_data,
	output logic res_valid,
	output oust_pkg::res_t res,
	input wire logic res_take
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_ACT,
		S_SH_RD,
		S_SH_WR,
		S_FIN
	} state_t;

	state_t state_q;
	logic [oust_pkg::ACTION_W-1:0] action_q;
	logic [oust_pkg::KEY_W-1:0] key_q;
	logic [oust_pkg::IDX_W-1:0] idx_q;
	logic [oust_pkg::CNT_W-1:0] held_q;
	logic hit_q;
	logic [oust_pkg::IDX_W-1:0] pos_q;
	logic [oust_pkg::STATUS_W-1:0] status_q;

	logic match;
	logic scan_last;
	logic add_ok;
	logic [oust_pkg::CNT_W-1:0] idx_ext;
	logic [oust_pkg::CNT_W-1:0] pos_ext;

	// Shared comparator and scan bounds
	assign match = (rd_data == key_q);
	assign idx_ext = oust_pkg::CNT_W'(idx_q);
	assign pos_ext = oust_pkg::CNT_W'(pos_q);
	assign scan_last = ((idx_ext + oust_pkg::CNT_W'(1)) == held_q);
	assign add_ok = (action_q == oust_pkg::ACT_ADD) && !hit_q
		&& (held_q != oust_pkg::CNT_W'(oust_pkg::CAPACITY));

	// Drive memory port from the current step
	always_comb begin
		ram_req.we = 1'b0;
		ram_req.waddr = oust_pkg::IDX_W'(held_q);
		ram_req.wdata = key_q;
		ram_req.raddr = idx_q;
		unique case (state_q)
			S_ACT: begin
				ram_req.we = add_ok;
			end
			S_SH_RD: begin
				ram_req.raddr = idx_q + oust_pkg::IDX_W'(1);
			end
			S_SH_WR: begin
				ram_req.we = 1'b1;
				ram_req.waddr = idx_q;
				ram_req.wdata = rd_data;
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res.found = hit_q;
	assign res.position = oust_pkg::POS_W'(pos_q);
	assign res.entry_count = oust_pkg::COUNT_W'(held_q);
	assign res.status = status_q;

	// Step the sequencer and hold its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q <= '0;
			hit_q <= 1'b0;
			pos_q <= '0;
			status_q <= oust_pkg::ST_DONE;
			idx_q <= '0;
			action_q <= oust_pkg::ACT_LOOKUP;
			key_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						action_q <= action;
						key_q <= oust_pkg::KEY_W'(key);
						idx_q <= '0;
						hit_q <= 1'b0;
						pos_q <= '0;
						state_q <= (held_q == '0) ? S_ACT : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (match) begin
						hit_q <= 1'b1;
						pos_q <= idx_q;
						state_q <= S_ACT;
					end else if (scan_last) begin
						state_q <= S_ACT;
					end else begin
						idx_q <= idx_q + oust_pkg::IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_ACT: begin
					state_q <= S_FIN;
					if (action_q == oust_pkg::ACT_ADD) begin
						if (hit_q) begin
							status_q <= oust_pkg::ST_PRESENT;
						end else if (!add_ok) begin
							status_q <= oust_pkg::ST_FULL;
						end else begin
							held_q <= held_q + oust_pkg::CNT_W'(1);
							status_q <= oust_pkg::ST_DONE;
						end
					end else if (action_q == oust_pkg::ACT_REMOVE) begin
						if (!hit_q) begin
							status_q <= oust_pkg::ST_ABSENT;
						end else begin
							status_q <= oust_pkg::ST_DONE;
							if ((pos_ext + oust_pkg::CNT_W'(1)) < held_q) begin
								idx_q <= pos_q;
								state_q <= S_SH_RD;
							end else begin
								held_q <= held_q - oust_pkg::CNT_W'(1);
							end
						end
					end else begin
						status_q <= hit_q ? oust_pkg::ST_DONE : oust_pkg::ST_ABSENT;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					// Move the next entry down; stop after the last one
					idx_q <= idx_q + oust_pkg::IDX_W'(1);
					if ((idx_ext + oust_pkg::CNT_W'(2)) < held_q) begin
						state_q <= S_SH_RD;
					end else begin
						held_q <= held_q - oust_pkg::CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ordered_unique_set_table_unit.sv -----
// Top level of the ordered unique set table: sequencer, entry memory, result register.
// Steps: a request scans the entries in order until a hit or the last held entry, then
// decides in one step, moves each later entry down on remove, and passes the result register.
// Requests: one at a time; the scan through the single memory read port and
// one comparator bounds how soon a request completes, longest for a full scan or a remove.
// Reset: arst_n clears the entry count and all control state; entry memory is not cleared.
`default_nettype none
module ordered_unique_set_table_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire logic [oust_pkg::ACTION_W-1:0] action,
	input wire logic [oust_pkg::KEY_PORT_W-1:0] key,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output logic found,
	output logic [oust_pkg::POS_W-1:0] position,
	output logic [oust_pkg::COUNT_W-1:0] entry_count,
	output logic [oust_pkg::STATUS_W-1:0] status
);

	oust_pkg::ram_req_t ram_req;
	oust_pkg::res_t res;
	oust_pkg::res_t res_q;
	logic [oust_pkg::KEY_W-1:0] rd_data;
	logic ctrl_idle;
	logic res_valid;
	logic res_take;
	logic rsp_valid_q;

	oust_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(req_valid),
		.action(action),
		.key(key),
		.idle(ctrl_idle),
		.ram_req(ram_req),
		.rd_data(rd_data),
		.res_valid(res_valid),
		.res(res),
		.res_take(res_take)
	);

	oust_ram #(
		.WIDTH(oust_pkg::KEY_W),
		.DEPTH(oust_pkg::CAPACITY)
	) u_entries (
		.clk(clk),
		.we(ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(rd_data)
	);

	assign req_ready = ctrl_idle;
	assign res_take = !rsp_valid_q || rsp_ready;

	// Hold the finished result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			res_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign found = res_q.found;
	assign position = res_q.position;
	assign entry_count = res_q.entry_count;
	assign status = res_q.status;

	// Count never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (entry_count <= oust_pkg::COUNT_W'(oust_pkg::CAPACITY)))
		else $error("entry count beyond capacity");

	// A miss reports position zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !found) |-> (position == '0))
		else $error("nonzero position on miss");

	// Full is only reported on a miss with the table at capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == oust_pkg::ST_FULL) |->
		(!found && entry_count == oust_pkg::COUNT_W'(oust_pkg::CAPACITY)))
		else $error("full status with room or hit");

	// Already-present is only reported on a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == oust_pkg::ST_PRESENT) |-> found)
		else $error("present status without hit");

	// No new request is taken while the sequencer is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while busy");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the ordered unique set table: scoreboard, drivers and run control.
`timescale 1ns / 100ps

import oust_pkg::*;

// Shadow of the key table that predicts each reply and checks the ones the block returns
class set_table_scoreboard;
	logic [KEY_W-1:0] shadow_keys[CAPACITY];
	int unsigned shadow_count;
	res_t pending_replies[$];
	int unsigned mismatches;
	int unsigned replies_checked;
	int unsigned full_rejects;
	int unsigned removals;
	int unsigned hits;

	function new();
		shadow_count = 0;
		mismatches = 0;
		replies_checked = 0;
		full_rejects = 0;
		removals = 0;
		hits = 0;
	endfunction

	// Apply one accepted request to the shadow table and queue the reply it must produce
	function void note_request(logic [ACTION_W-1:0] act, logic [KEY_PORT_W-1:0] req_key);
		res_t reply;
		logic [KEY_W-1:0] k;
		logic [STATUS_W-1:0] st;
		int unsigned slot;
		int unsigned i;
		bit hit;
		k = req_key[KEY_W-1:0];
		hit = 1'b0;
		slot = 0;
		for (i = 0; i < shadow_count; i++) begin
			if (!hit && shadow_keys[i] == k) begin
				hit = 1'b1;
				slot = i;
			end
		end
		if (hit)
			hits++;
		case (act)
			ACT_ADD: begin
				if (hit) begin
					st = ST_PRESENT;
				end else if (shadow_count >= CAPACITY) begin
					st = ST_FULL;
					full_rejects++;
				end else begin
					shadow_keys[shadow_count] = k;
					shadow_count++;
					st = ST_DONE;
				end
			end
			ACT_REMOVE: begin
				if (!hit) begin
					st = ST_ABSENT;
				end else begin
					// close the gap so the remaining keys keep their order
					for (i = slot; i + 1 < shadow_count; i++)
						shadow_keys[i] = shadow_keys[i + 1];
					shadow_count--;
					st = ST_DONE;
					removals++;
				end
			end
			// lookup, and the unused code that acts as one
			default: st = hit ? ST_DONE : ST_ABSENT;
		endcase
		reply.found = hit;
		reply.position = slot[POS_W-1:0];
		reply.entry_count = shadow_count[COUNT_W-1:0];
		reply.status = st;
		pending_replies.push_back(reply);
	endfunction

	// Compare one returned reply against the oldest pending one
	function void check_response(res_t got);
		res_t want;
		if (pending_replies.size() == 0) begin
			$error("reply with no request pending: found=%0d position=%0d entry_count=%0d status=%0d",
				got.found, got.position, got.entry_count, got.status);
			mismatches++;
			return;
		end
		want = pending_replies.pop_front();
		replies_checked++;
		if (got.found !== want.found) begin
			$error("found: expected %0d, actual %0d", want.found, got.found);
			mismatches++;
		end
		if (got.position !== want.position) begin
			$error("position: expected %0d, actual %0d", want.position, got.position);
			mismatches++;
		end
		if (got.entry_count !== want.entry_count) begin
			$error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
			mismatches++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, got.status);
			mismatches++;
		end
	endfunction
endclass

module testbench;

	// Action code the block does not name; it must behave as a lookup
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int BIAS_SPAN = 40;
	localparam int POOL_SIZE = 24;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [ACTION_W-1:0] action = ACT_LOOKUP;
	logic [KEY_PORT_W-1:0] key = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic found;
	logic [POS_W-1:0] position;
	logic [COUNT_W-1:0] entry_count;
	logic [STATUS_W-1:0] status;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned requests_sent = 0;
	logic [KEY_PORT_W-1:0] key_pool[POOL_SIZE];

	set_table_scoreboard set_board = new();

	ordered_unique_set_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.key(key),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.found(found),
		.position(position),
		.entry_count(entry_count),
		.status(status)
	);

	// Run the clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Stall the reply channel at random
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Check every reply transaction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			set_board.check_response({found, position, entry_count, status});
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still pending",
				cycle_count, set_board.pending_replies.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one request transaction, idling first at random, and note it once accepted
	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_PORT_W-1:0] k);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		action = act;
		key = k;
		do
			@(posedge clk);
		while (!req_ready);
		set_board.note_request(act, k);
		requests_sent++;
		@(negedge clk);
	endtask

	// Hold the request channel idle until every pending reply has come back
	task automatic wait_for_replies();
		req_valid = 1'b0;
		while (set_board.pending_replies.size() != 0)
			@(negedge clk);
	endtask

	// Hit the empty, duplicate, full and shifting cases by hand
	task automatic run_directed();
		int n;
		send_request(ACT_LOOKUP, 32'h0000_0000);
		send_request(ACT_REMOVE, 32'h0000_0000);
		send_request(ACT_ADD, 32'h0000_0000);
		send_request(ACT_ADD, 32'hFFFF_FFFF);
		send_request(ACT_ADD, 32'h0000_0000);
		send_request(ACT_LOOKUP, 32'hFFFF_FFFF);
		send_request(ACT_SPARE, 32'h0000_0000);
		for (n = 0; n < CAPACITY - 2; n++)
			send_request(ACT_ADD, 32'h1357_9BDF ^ (n * 32'h0101_0101));
		send_request(ACT_ADD, 32'h8000_0001);
		send_request(ACT_ADD, 32'hFFFF_FFFF);
		send_request(ACT_LOOKUP, 32'h1357_9BDF ^ (13 * 32'h0101_0101));
		send_request(ACT_REMOVE, 32'h0000_0000);
		send_request(ACT_REMOVE, 32'h1357_9BDF ^ (13 * 32'h0101_0101));
		send_request(ACT_REMOVE, 32'h1357_9BDF ^ (6 * 32'h0101_0101));
		send_request(ACT_REMOVE, 32'h8000_0001);
	endtask

	// Draw keys mostly from a small pool so hits, duplicates and a full table are common
	function automatic logic [KEY_PORT_W-1:0] pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom();
	endfunction

	// Lean toward adds or removes so the table swings between empty and full
	function automatic logic [ACTION_W-1:0] pick_action(bit fill_bias);
		int unsigned r;
		r = $urandom_range(99);
		if (r >= 95)
			return ACT_SPARE;
		if (fill_bias)
			return (r < 50) ? ACT_ADD : (r < 70) ? ACT_REMOVE : ACT_LOOKUP;
		return (r < 25) ? ACT_ADD : (r < 65) ? ACT_REMOVE : ACT_LOOKUP;
	endfunction

	// One idling setting: drain, refresh the key pool, then send random requests
	task automatic run_phase(input int idle_pct, input int stall_pct);
		int n;
		bit fill_bias;
		wait_for_replies();
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (n = 0; n < POOL_SIZE; n++)
			key_pool[n] = $urandom();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		fill_bias = 1'b1;
		for (n = 0; n < ITEMS_PER_PHASE; n++) begin
			if (n % BIAS_SPAN == BIAS_SPAN - 1)
				fill_bias = !fill_bias;
			send_request(pick_action(fill_bias), pick_key());
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		run_phase(0, 0);
		run_phase(52, 0);
		run_phase(0, 52);
		run_phase(15, 15);

		// let the last replies land, then watch for strays
		wait_for_replies();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (set_board.pending_replies.size() != 0) begin
			$error("%0d replies never returned", set_board.pending_replies.size());
			set_board.mismatches++;
		end

		$display("Covered %0d requests over four idling settings; %0d replies checked.",
			requests_sent, set_board.replies_checked);
		$display("Saw %0d hits, %0d removals and %0d adds refused on a full table; %0d mismatches.",
			set_board.hits, set_board.removals, set_board.full_rejects, set_board.mismatches);
		if (set_board.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/oust_pkg.sv
hdl/oust_ram.sv
hdl/oust_ctrl.sv
hdl/ordered_unique_set_table_unit.sv
tb/sv/testbench.sv
